### src/stpa_pkg.sv
// ----------------------------------------------------------------------------
// stpa_pkg
// Shared types, codes and IEEE double helpers for the sparse triple-product
// accumulator.
// ----------------------------------------------------------------------------
package stpa_pkg;

  localparam int COL_W      = 12;
  localparam int IN_DATA_W  = 400;
  localparam int OUT_DATA_W = 208;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;

  // register index (paddr[2])
  localparam logic REG_MODE = 1'b0;

  localparam logic [1:0] MODE_DIAG1   = 2'd0;
  localparam logic [1:0] MODE_DIAG2   = 2'd1;
  localparam logic [1:0] MODE_DIAG3   = 2'd2;
  localparam logic [1:0] MODE_OFFDIAG = 2'd3;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_APPLY = 1'b1
  } op_t;

  typedef logic signed [13:0] fexp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } fu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } fu_rsp_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    fexp_t       e;
    logic [52:0] m;
  } fp_unp_t;

  function automatic fp_unp_t fp_unpack(input logic [63:0] x);
    fp_unp_t u;
    u.sign = x[63];
    u.nan  = (x[62:52] == 11'h7FF) && (x[51:0] != '0);
    u.inf  = (x[62:52] == 11'h7FF) && (x[51:0] == '0);
    u.zero = (x[62:0] == '0);
    u.m    = {(x[62:52] != '0), x[51:0]};
    u.e    = (x[62:52] == '0) ? fexp_t'(1) : fexp_t'({3'b0, x[62:52]});
    return u;
  endfunction

  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // m: bit 55 integer, 54:3 fraction, 2 guard, 1 round, 0 sticky.
  // Value m/2^55 * 2^(e-1023). Handles subnormal results and overflow.
  function automatic logic [63:0] fp_round(input logic s, input fexp_t e,
                                           input logic [55:0] m);
    logic [6:0]   sh;
    logic [111:0] w;
    logic [55:0]  mm;
    logic [10:0]  eu;
    logic [62:0]  mag;
    logic         inc;
    sh = '0;
    w  = '0;
    mm = m;
    eu = e[10:0];
    if (e >= fexp_t'(2047)) return {s, INF_MAG};
    if (e < fexp_t'(1)) begin
      sh = (e < fexp_t'(-61)) ? 7'd63 : 7'(fexp_t'(1) - e);
      w  = {m, 56'b0} >> sh;
      mm = {w[111:57], w[56] | (|w[55:0])};
      eu = 11'd1;
    end
    mag = {(mm[55] ? eu : 11'd0), mm[54:3]};
    inc = mm[2] & (mm[1] | mm[0] | mm[3]);
    // carry out of the fraction bumps the exponent (incl. to infinity)
    return {s, mag + 63'(inc)};
  endfunction

endpackage

### src/stpa_fdiv.sv
// ----------------------------------------------------------------------------
// stpa_fdiv
// Double precision divider, restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stpa_fdiv (
  input  logic              clk,
  input  logic              rst,
  input  stpa_pkg::fu_req_t req,
  output stpa_pkg::fu_rsp_t rsp
);
  import stpa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LZC, S_ALIGN, S_ITER, S_ROUND} state_t;

  state_t      state;
  fp_unp_t     na, nb, ua, ub;
  logic [6:0]  lza, lzb;
  logic [52:0] divisor;
  logic [54:0] rem;
  logic [55:0] quo;
  logic [5:0]  cnt;
  logic        sign;
  fexp_t       qexp;

  assign na = fp_unpack(req.a);
  assign nb = fp_unpack(req.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            ua   <= na;
            ub   <= nb;
            sign <= req.a[63] ^ req.b[63];
            if (na.nan || nb.nan || (na.inf && nb.inf) || (na.zero && nb.zero)) begin
              rsp.value <= QNAN_BITS;
              rsp.done  <= 1'b1;
            end else if (na.inf || nb.zero) begin
              rsp.value <= {req.a[63] ^ req.b[63], INF_MAG};
              rsp.done  <= 1'b1;
            end else if (na.zero || nb.inf) begin
              rsp.value <= {req.a[63] ^ req.b[63], 63'b0};
              rsp.done  <= 1'b1;
            end else begin
              state <= S_LZC;
            end
          end
        end
        S_LZC: begin
          lza   <= lzc64({ua.m, 11'b0});
          lzb   <= lzc64({ub.m, 11'b0});
          state <= S_ALIGN;
        end
        S_ALIGN: begin
          rem     <= {2'b0, 53'(ua.m << lza)};
          divisor <= 53'(ub.m << lzb);
          qexp    <= fexp_t'((ua.e - $signed({1'b0, lza})) - (ub.e - $signed({1'b0, lzb}))
                             + 1023);
          cnt     <= '0;
          state   <= S_ITER;
        end
        S_ITER: begin
          if (rem >= {2'b0, divisor}) begin
            rem <= 55'((rem - {2'b0, divisor}) << 1);
            quo <= {quo[54:0], 1'b1};
          end else begin
            rem <= 55'(rem << 1);
            quo <= {quo[54:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) state <= S_ROUND;
        end
        S_ROUND: begin
          if (quo[55])
            rsp.value <= fp_round(sign, qexp, {quo[55:1], quo[0] | (rem != '0)});
          else
            rsp.value <= fp_round(sign, qexp - fexp_t'(1), {quo[54:0], (rem != '0)});
          rsp.done <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/stpa_fmul.sv
// ----------------------------------------------------------------------------
// stpa_fmul
// Double precision multiplier; 53x53 significand product built from four
// 27x27 partial products, one per cycle.
// ----------------------------------------------------------------------------
module stpa_fmul (
  input  logic              clk,
  input  logic              rst,
  input  stpa_pkg::fu_req_t req,
  output stpa_pkg::fu_rsp_t rsp
);
  import stpa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LZC, S_ALIGN, S_MUL, S_ROUND} state_t;

  state_t       state;
  fp_unp_t      na, nb, ua, ub;
  logic [6:0]   lza, lzb;
  logic [52:0]  opa, opb;
  logic [26:0]  pa, pb;
  logic [53:0]  pp;
  logic [6:0]   pp_sh;
  logic [105:0] prod;
  logic [2:0]   cnt;
  logic         sign;
  fexp_t        pexp;

  assign na = fp_unpack(req.a);
  assign nb = fp_unpack(req.b);
  assign pa = cnt[0] ? {1'b0, opa[52:27]} : opa[26:0];
  assign pb = cnt[1] ? {1'b0, opb[52:27]} : opb[26:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            ua   <= na;
            ub   <= nb;
            sign <= req.a[63] ^ req.b[63];
            if (na.nan || nb.nan || (na.inf && nb.zero) || (na.zero && nb.inf)) begin
              rsp.value <= QNAN_BITS;
              rsp.done  <= 1'b1;
            end else if (na.inf || nb.inf) begin
              rsp.value <= {req.a[63] ^ req.b[63], INF_MAG};
              rsp.done  <= 1'b1;
            end else if (na.zero || nb.zero) begin
              rsp.value <= {req.a[63] ^ req.b[63], 63'b0};
              rsp.done  <= 1'b1;
            end else begin
              state <= S_LZC;
            end
          end
        end
        S_LZC: begin
          lza   <= lzc64({ua.m, 11'b0});
          lzb   <= lzc64({ub.m, 11'b0});
          state <= S_ALIGN;
        end
        S_ALIGN: begin
          opa   <= 53'(ua.m << lza);
          opb   <= 53'(ub.m << lzb);
          pexp  <= fexp_t'((ua.e - $signed({1'b0, lza})) + (ub.e - $signed({1'b0, lzb}))
                           - 1023);
          prod  <= '0;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // partial product of this cycle, accumulate the previous one
          if (cnt != 3'd4) begin
            pp    <= pa * pb;
            pp_sh <= (cnt[0] & cnt[1]) ? 7'd54 : ((cnt[0] | cnt[1]) ? 7'd27 : 7'd0);
          end
          if (cnt != 3'd0) prod <= prod + (106'(pp) << pp_sh);
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) state <= S_ROUND;
        end
        S_ROUND: begin
          if (prod[105])
            rsp.value <= fp_round(sign, pexp + fexp_t'(1), {prod[105:51], |prod[50:0]});
          else
            rsp.value <= fp_round(sign, pexp, {prod[104:50], |prod[49:0]});
          rsp.done <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/stpa_fadd.sv
// ----------------------------------------------------------------------------
// stpa_fadd
// Double precision adder: align, add, leading-zero count, normalize, round.
// ----------------------------------------------------------------------------
module stpa_fadd (
  input  logic              clk,
  input  logic              rst,
  input  stpa_pkg::fu_req_t req,
  output stpa_pkg::fu_rsp_t rsp
);
  import stpa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ALN, S_SUM, S_LZC, S_NRM, S_RND} state_t;

  state_t       state;
  fp_unp_t      na, nb, ubig, usm;
  logic [63:0]  av, bv, big, small_op;
  fexp_t        d;
  logic [6:0]   sh;
  logic [111:0] w;
  logic [55:0]  big56, sm56, m;
  logic [56:0]  s57;
  logic [6:0]   lz;
  logic         sign, sub, zs;
  fexp_t        e;

  assign na = fp_unpack(req.a);
  assign nb = fp_unpack(req.b);

  // alignment of the smaller magnitude
  always_comb begin
    big      = (av[62:0] >= bv[62:0]) ? av : bv;
    small_op = (av[62:0] >= bv[62:0]) ? bv : av;
    ubig     = fp_unpack(big);
    usm      = fp_unpack(small_op);
    d        = ubig.e - usm.e;
    sh       = (d > fexp_t'(56)) ? 7'd57 : d[6:0];
    w        = {usm.m, 3'b0, 56'b0} >> sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            av <= req.a;
            bv <= req.b;
            if (na.nan || nb.nan || (na.inf && nb.inf && (req.a[63] != req.b[63]))) begin
              rsp.value <= QNAN_BITS;
              rsp.done  <= 1'b1;
            end else if (na.inf) begin
              rsp.value <= req.a;
              rsp.done  <= 1'b1;
            end else if (nb.inf) begin
              rsp.value <= req.b;
              rsp.done  <= 1'b1;
            end else begin
              state <= S_ALN;
            end
          end
        end
        S_ALN: begin
          big56 <= {ubig.m, 3'b0};
          sm56  <= {w[111:57], w[56] | (|w[55:0])};
          e     <= ubig.e;
          sign  <= big[63];
          sub   <= av[63] ^ bv[63];
          zs    <= av[63] & bv[63];
          state <= S_SUM;
        end
        S_SUM: begin
          s57   <= sub ? ({1'b0, big56} - {1'b0, sm56}) : ({1'b0, big56} + {1'b0, sm56});
          state <= S_LZC;
        end
        S_LZC: begin
          if (s57 == '0) begin
            // exact zero: negative only when both operands were negative
            rsp.value <= {zs, 63'b0};
            rsp.done  <= 1'b1;
            state     <= S_IDLE;
          end else if (s57[56]) begin
            m     <= {s57[56:2], s57[1] | s57[0]};
            e     <= e + fexp_t'(1);
            state <= S_RND;
          end else begin
            lz    <= lzc64({s57[55:0], 8'b0});
            state <= S_NRM;
          end
        end
        S_NRM: begin
          m     <= 56'(s57[55:0] << lz);
          e     <= e - $signed({1'b0, lz});
          state <= S_RND;
        end
        S_RND: begin
          rsp.value <= fp_round(sign, e, m);
          rsp.done  <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/sparse_triple_product_accumulator.sv
// ----------------------------------------------------------------------------
// sparse_triple_product_accumulator
// Row-wise sparse accumulator for A -= G~ M^-1 G in double precision.
//
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   s_tuser op, s_tdata operands
//  m_*      out  m_tvalid / m_tready   m_tdata column and updated entries
//  apb      in   psel/penable/pwrite   paddr, pwdata (mode), prdata
//
// One item at a time. Accumulate: a division on the bit-serial divider (56
// iterations), then a multiply and an add on the multiplier and adder.
// Apply: three subtractions on the shared adder.
// After reset the accumulator memory is cleared, one word per cycle,
// min(DOF_COUNT, 4096) words, during which s_tready stays low.
// A finished result waits in the output register while the next
// transaction is taken; an apply stalls at its end until that register frees.
// ----------------------------------------------------------------------------
module sparse_triple_product_accumulator #(
  parameter int DOF_COUNT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // column, tilde_g_value, mass_value, g_value, a_first, a_second, a_third
  input  logic [stpa_pkg::IN_DATA_W-1:0] s_tdata,
  // op
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_column, new_first, new_second, new_third
  output logic [stpa_pkg::OUT_DATA_W-1:0] m_tdata
);
  import stpa_pkg::*;

  localparam int MEM_DEPTH = (DOF_COUNT < 4096) ? DOF_COUNT : 4096;
  localparam int AW        = $clog2(MEM_DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD, ST_DIV, ST_MUL, ST_ADD, ST_WRITE,
    ST_HALF, ST_SUB, ST_SUBW, ST_OUT
  } state_t;

  state_t           state;
  logic [1:0]       mode;
  op_t              op;
  logic [COL_W-1:0] col;
  logic [63:0]      tg, mass, gv, a1, a2, a3;
  logic [63:0]      vacc, half, tmp, res0, res1, res2;
  logic [1:0]       sub_idx;
  logic [63:0]      sub_a, sub_b;
  logic [AW-1:0]    clr_addr, item_addr, mem_waddr;
  logic             in_range, mem_we, out_free;
  logic [63:0]      mem_wdata, mem_q;
  logic [63:0]      acc_mem [MEM_DEPTH];
  fp_unp_t          uv;
  fu_req_t          div_req, mul_req, add_req;
  fu_rsp_t          div_rsp, mul_rsp, add_rsp;
  logic [COL_W-1:0] out_col;
  logic [63:0]      out_first, out_second, out_third;

  stpa_fdiv u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  stpa_fmul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  stpa_fadd u_add (.clk(clk), .rst(rst), .req(add_req), .rsp(add_rsp));

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {30'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DIAG1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
      mode <= pwdata[1:0];
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign in_range  = (int'(col) < DOF_COUNT);
  assign item_addr = col[AW-1:0];
  assign out_free  = !m_tvalid || m_tready;
  assign uv        = fp_unpack(vacc);
  assign m_tdata   = {4'b0, out_third, out_second, out_first, out_col};

  // memory port
  always_comb begin
    mem_we    = (state == ST_CLEAR) || (state == ST_WRITE) ||
                ((state == ST_OUT) && in_range && out_free);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : item_addr;
    mem_wdata = (state == ST_WRITE) ? tmp : 64'b0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) acc_mem[mem_waddr] <= mem_wdata;
    mem_q <= acc_mem[item_addr];
  end

  always_comb begin
    unique case (sub_idx)
      2'd0: begin
        sub_a = a1;
        sub_b = (mode == MODE_DIAG1) ? vacc : half;
      end
      2'd1: begin
        sub_a = a2;
        sub_b = (mode == MODE_DIAG2) ? vacc : half;
      end
      default: begin
        sub_a = a3;
        sub_b = (mode == MODE_DIAG3) ? vacc : half;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      m_tvalid      <= 1'b0;
      div_req.start <= 1'b0;
      mul_req.start <= 1'b0;
      add_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      mul_req.start <= 1'b0;
      add_req.start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            op    <= op_t'(s_tuser[0]);
            col   <= s_tdata[11:0];
            tg    <= s_tdata[75:12];
            mass  <= s_tdata[139:76];
            gv    <= s_tdata[203:140];
            a1    <= s_tdata[267:204];
            a2    <= s_tdata[331:268];
            a3    <= s_tdata[395:332];
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (op == OP_ACCUM) begin
            if (in_range) begin
              div_req <= '{start: 1'b1, a: tg, b: mass};
              state   <= ST_LOAD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          vacc  <= in_range ? mem_q : 64'b0;
          state <= (op == OP_ACCUM) ? ST_DIV : ST_HALF;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            mul_req <= '{start: 1'b1, a: div_rsp.value, b: gv};
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            add_req <= '{start: 1'b1, a: vacc, b: mul_rsp.value};
            state   <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (add_rsp.done) begin
            tmp   <= add_rsp.value;
            state <= ST_WRITE;
          end
        end
        ST_WRITE: state <= ST_IDLE;
        ST_HALF: begin
          if (uv.nan)                half <= QNAN_BITS;
          else if (uv.inf || uv.zero) half <= vacc;
          else half <= fp_round(vacc[63], uv.e - fexp_t'(1), {uv.m, 3'b0});
          sub_idx <= 2'd0;
          state   <= ST_SUB;
        end
        ST_SUB: begin
          add_req <= '{start: 1'b1, a: sub_a, b: {~sub_b[63], sub_b[62:0]}};
          state   <= ST_SUBW;
        end
        ST_SUBW: begin
          if (add_rsp.done) begin
            unique case (sub_idx)
              2'd0:    res0 <= add_rsp.value;
              2'd1:    res1 <= add_rsp.value;
              default: res2 <= add_rsp.value;
            endcase
            if (sub_idx == 2'd2) begin
              state <= ST_OUT;
            end else begin
              sub_idx <= sub_idx + 2'd1;
              state   <= ST_SUB;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_col    <= col;
            out_first  <= res0;
            out_second <= (mode == MODE_OFFDIAG) ? a2 : res1;
            out_third  <= (mode == MODE_OFFDIAG) ? a3 : res2;
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({div_req.start, mul_req.start, add_req.start}))
    else $error("two arithmetic units started together");

  a_out_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (op == OP_APPLY))
    else $error("result raised by an accumulate transaction");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (op == OP_ACCUM) && in_range)
    else $error("accumulator write for an invalid transaction");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_READ))
    else $error("accepted transaction not started");
`endif

endmodule

### tb/tb_sparse_triple_product_accumulator.sv
// ----------------------------------------------------------------------------
// tb_sparse_triple_product_accumulator
// Self-checking bench for the sparse triple-product accumulator.
// Accumulate and apply transactions go in through the slave stream. Every
// apply is predicted with a double-precision model of the accumulator rows
// or given a fixed expectation, and compared field by field with the master stream.
// The mode register is swept over all values between phases.
// ----------------------------------------------------------------------------
module tb_sparse_triple_product_accumulator;
  import stpa_pkg::*;

  localparam int          NCOLS       = 4096;
  localparam logic [2:0]  ADDR_MODE   = 3'd0;
  localparam logic [2:0]  ADDR_SPARE  = 3'd4;   // no register here, writes ignored
  localparam int          DRAIN_WAIT  = 250;
  localparam int          STALL_LIMIT = 30000;
  localparam logic [63:0] D_ZERO      = 64'h0000_0000_0000_0000;
  localparam logic [63:0] D_NZERO     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] D_ONE       = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] D_MONE      = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] D_TWO       = 64'h4000_0000_0000_0000;
  localparam logic [63:0] D_MTWO      = 64'hC000_0000_0000_0000;
  localparam logic [63:0] D_THREE     = 64'h4008_0000_0000_0000;
  localparam logic [63:0] D_FOUR      = 64'h4010_0000_0000_0000;
  localparam logic [63:0] D_SEVEN     = 64'h401C_0000_0000_0000;
  localparam logic [63:0] D_TEN       = 64'h4024_0000_0000_0000;
  localparam logic [63:0] D_HALF      = 64'h3FE0_0000_0000_0000;
  localparam logic [63:0] D_ONEHALF   = 64'h3FF8_0000_0000_0000;
  localparam logic [63:0] D_PINF      = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] D_NINF      = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] D_MAXN      = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] D_MINSUB    = 64'h0000_0000_0000_0001;
  localparam logic [63:0] D_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    op_t         op;
    logic [11:0] col;
    logic [63:0] tg, mass, g, a1, a2, a3;
  } entry_t;

  typedef struct {
    logic [11:0] col;
    logic [63:0] f1, f2, f3;
  } update_t;

  typedef struct {
    entry_t  e;
    bit      typed;
    update_t r;
  } row_t;

  logic                   clk, rst;
  logic                   psel, penable, pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata, prdata;
  logic                   pready;
  logic                   s_tvalid, s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;   // column, tilde_g, mass, g, a_first, a_second, a_third
  logic [0:0]             s_tuser;   // op
  logic                   m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;   // out_column, new_first, new_second, new_third

  sparse_triple_product_accumulator dut (.*);

  real         row_acc [NCOLS];
  logic [1:0]  cur_mode;
  update_t     pending_updates[$];
  int          errors, n_accum, n_apply, n_results, idle_cycles, burst_left;
  bit          holdoff_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_nan(logic [63:0] b);
    return b[62:52] == 11'h7FF && b[51:0] != 0;
  endfunction

  function automatic logic [63:0] canon(real d);
    logic [63:0] b;
    b = $realtobits(d);
    return is_nan(b) ? QNAN_BITS : b;
  endfunction

  // Divide with the zero-mass rules spelled out; IEEE elsewhere.
  function automatic real safe_quot(logic [63:0] n, logic [63:0] m);
    if (m[62:0] == 0) begin
      if (is_nan(n) || n[62:0] == 0) return $bitstoreal(QNAN_BITS);
      return $bitstoreal({n[63] ^ m[63], 63'h7FF0_0000_0000_0000});
    end
    return $bitstoreal(n) / $bitstoreal(m);
  endfunction

  // Advance the row accumulators; returns 1 and fills upd for an apply.
  function automatic bit predict_entry_update(entry_t e, output update_t upd);
    real q, p, v, h;
    upd = '{default: '0};
    if (e.op == OP_ACCUM) begin
      q = safe_quot(e.tg, e.mass);
      p = q * $bitstoreal(e.g);
      row_acc[e.col] = row_acc[e.col] + p;
      return 0;
    end
    v = row_acc[e.col];
    h = v / 2.0;
    upd.col = e.col;
    case (cur_mode)
      MODE_DIAG1: begin
        upd.f1 = canon($bitstoreal(e.a1) - v);
        upd.f2 = canon($bitstoreal(e.a2) - h);
        upd.f3 = canon($bitstoreal(e.a3) - h);
      end
      MODE_DIAG2: begin
        upd.f1 = canon($bitstoreal(e.a1) - h);
        upd.f2 = canon($bitstoreal(e.a2) - v);
        upd.f3 = canon($bitstoreal(e.a3) - h);
      end
      MODE_DIAG3: begin
        upd.f1 = canon($bitstoreal(e.a1) - h);
        upd.f2 = canon($bitstoreal(e.a2) - h);
        upd.f3 = canon($bitstoreal(e.a3) - v);
      end
      default: begin
        upd.f1 = canon($bitstoreal(e.a1) - h);
        upd.f2 = e.a2;
        upd.f3 = e.a3;
      end
    endcase
    row_acc[e.col] = 0.0;
    return 1;
  endfunction

  function automatic logic [63:0] rand_double();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70)
      return {1'($urandom), 11'($urandom_range(1013, 1033)), 20'($urandom), 32'($urandom)};
    if (k < 82) return {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return D_ZERO;
      1: return D_NZERO;
      2: return D_PINF;
      3: return D_NINF;
      4: return {12'h7FF, 20'($urandom) | 20'h1, 32'($urandom)};
      5: return D_MINSUB;
      default: return D_MAXN;
    endcase
  endfunction

  function automatic logic [11:0] rand_col();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic entry_t rand_entry(op_t op, logic [11:0] col);
    entry_t e;
    e.op   = op;
    e.col  = col;
    e.tg   = rand_double();
    e.mass = ($urandom_range(0, 19) == 0) ? rand_double() :
             {1'($urandom), 11'($urandom_range(1013, 1033)), 20'($urandom), 32'($urandom)};
    e.g    = rand_double();
    e.a1   = rand_double();
    e.a2   = rand_double();
    e.a3   = rand_double();
    return e;
  endfunction

  // Offer one transaction, in bursts with random gaps.
  task automatic send_entry(entry_t e, bit typed, update_t r);
    int      gap;
    update_t upd;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= e.op;
    s_tdata  <= {4'b0, e.a3, e.a2, e.a1, e.g, e.mass, e.tg, e.col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (predict_entry_update(e, upd)) begin
      pending_updates.push_back(typed ? r : upd);
      n_apply++;
    end else begin
      n_accum++;
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MODE) cur_mode = data[1:0];
  endtask

  // Config only once the block is drained, plus room for a trailing accumulate.
  task automatic set_mode(logic [1:0] m);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    apb_write(ADDR_SPARE, $urandom);
    apb_write(ADDR_MODE, {30'($urandom), m});
  endtask

  // Output side: random stalls, one long hold-off.
  initial begin
    int hold;
    bit held;
    m_tready = 1'b0;
    held = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req && !held) begin
        held = 1;
        hold = 500;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if ((n_accum + n_apply) % 400 < 100) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    update_t x;
    if (m_tvalid && m_tready) begin
      n_results++;
      if (pending_updates.size() == 0) begin
        $error("unexpected result transaction, column %0d", m_tdata[11:0]);
        errors++;
      end else begin
        x = pending_updates.pop_front();
        if (m_tdata[11:0] !== x.col) begin
          $error("out_column: expected %0d, got %0d", x.col, m_tdata[11:0]);
          errors++;
        end
        if (m_tdata[75:12] !== x.f1) begin
          $error("new_first: expected %h, got %h", x.f1, m_tdata[75:12]);
          errors++;
        end
        if (m_tdata[139:76] !== x.f2) begin
          $error("new_second: expected %h, got %h", x.f2, m_tdata[139:76]);
          errors++;
        end
        if (m_tdata[203:140] !== x.f3) begin
          $error("new_third: expected %h, got %h", x.f3, m_tdata[203:140]);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any transaction on either stream or the APB bus.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("** sparse_triple_product_accumulator: FAILED **");
      $finish;
    end
  end

  initial begin
    row_t        rows[$];
    entry_t      e;
    update_t     nil;
    logic [11:0] cols[3];
    int          ncols, nacc, quota;

    errors = 0; n_accum = 0; n_apply = 0; n_results = 0;
    idle_cycles = 0; burst_left = 0; holdoff_req = 0;
    cur_mode = MODE_DIAG1;
    foreach (row_acc[i]) row_acc[i] = 0.0;
    nil = '{default: '0};
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: fresh rows, extremes, zero mass, NaN handling
    rows = '{
      '{'{OP_APPLY, 12'd0, D_ZERO, D_ZERO, D_ZERO, D_ONE, D_TWO, D_THREE}, 1,
        '{12'd0, D_ONE, D_TWO, D_THREE}},
      '{'{OP_APPLY, 12'hFFF, D_ONES, D_ONES, D_ONES, D_ONES, D_ONES, D_ONES}, 1,
        '{12'hFFF, QNAN_BITS, QNAN_BITS, QNAN_BITS}},
      '{'{OP_ACCUM, 12'd5, D_TWO, D_ONE, D_THREE, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_APPLY, 12'd5, D_ZERO, D_ZERO, D_ZERO, D_TEN, D_TEN, D_TEN}, 1,
        '{12'd5, D_FOUR, D_SEVEN, D_SEVEN}},
      '{'{OP_APPLY, 12'd5, D_ZERO, D_ZERO, D_ZERO, D_TEN, D_TEN, D_TEN}, 1,
        '{12'd5, D_TEN, D_TEN, D_TEN}},
      '{'{OP_ACCUM, 12'd7, D_ONE, D_ZERO, D_ONE, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_APPLY, 12'd7, D_ZERO, D_ZERO, D_ZERO, D_ZERO, D_ZERO, D_ZERO}, 1,
        '{12'd7, D_NINF, D_NINF, D_NINF}},
      '{'{OP_ACCUM, 12'd8, D_ZERO, D_ZERO, D_ONE, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_APPLY, 12'd8, D_ZERO, D_ZERO, D_ZERO, D_ONE, D_ONE, D_ONE}, 1,
        '{12'd8, QNAN_BITS, QNAN_BITS, QNAN_BITS}},
      '{'{OP_ACCUM, 12'd9, D_MONE, D_NZERO, D_MONE, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_ACCUM, 12'd9, D_ONES, D_TWO, D_ONE, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_APPLY, 12'd9, D_ZERO, D_ZERO, D_ZERO, D_ONE, D_ONE, D_ONE}, 0, nil},
      '{'{OP_ACCUM, 12'd10, D_MAXN, D_MINSUB, D_MAXN, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_APPLY, 12'd10, D_ZERO, D_ZERO, D_ZERO, D_MAXN, D_NINF, D_MINSUB}, 0, nil},
      '{'{OP_ACCUM, 12'hFFF, D_ONEHALF, D_HALF, D_MTWO, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_ACCUM, 12'hFFF, D_MINSUB, D_MAXN, D_MINSUB, D_ZERO, D_ZERO, D_ZERO}, 0, nil},
      '{'{OP_APPLY, 12'hFFF, D_ZERO, D_ZERO, D_ZERO, D_NZERO, D_PINF, D_MAXN}, 0, nil},
      '{'{OP_APPLY, 12'd11, D_ZERO, D_ZERO, D_ZERO, D_NZERO, D_NZERO, D_NZERO}, 0, nil}
    };
    foreach (rows[i]) send_entry(rows[i].e, rows[i].typed, rows[i].r);

    // random phases: mode sweep, then random modes
    for (int ph = 0; ph < 8; ph++) begin
      set_mode(ph < 4 ? 2'(ph) : 2'($urandom));
      quota = n_accum + n_apply + 240;
      while (n_accum + n_apply < quota) begin
        if (ph == 1 && !holdoff_req && n_accum + n_apply > quota - 200) holdoff_req = 1;
        if ($urandom_range(0, 9) == 0) begin
          // noise: lone transaction of either kind
          send_entry(rand_entry(op_t'($urandom_range(0, 1)), rand_col()), 0, nil);
        end else begin
          // well-formed row: products into a few columns, then apply most of them
          ncols = $urandom_range(1, 3);
          for (int c = 0; c < ncols; c++) cols[c] = rand_col();
          nacc = $urandom_range(1, 6);
          for (int k = 0; k < nacc; k++)
            send_entry(rand_entry(OP_ACCUM, cols[$urandom_range(0, ncols - 1)]), 0, nil);
          for (int c = 0; c < ncols; c++)
            if ($urandom_range(0, 7) != 0) send_entry(rand_entry(OP_APPLY, cols[c]), 0, nil);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d accumulate and %0d apply transactions, %0d results checked,",
             n_accum, n_apply, n_results);
    $display("all four modes, zero mass, NaN and infinity operands, long output stall");
    if (errors == 0) begin
      $display("** sparse_triple_product_accumulator: PASSED **");
    end else begin
      $display("** sparse_triple_product_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
